/* rtl/core/akes_pkg.sv */
package akes_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_STEPS = 15;
   localparam int DT_FRAC = 16;
   localparam int ANG_FRAC = 30;
   localparam int ANG_UP = ANG_FRAC - FRAC_BITS;
   localparam int CORDIC_ITERS = 24;
   localparam int DT_W = 21;
   localparam int NUM_W = 53;
   localparam int SAT_W = 70;
   localparam logic [DT_W-1:0] DT_RESET = 21'd32768;

   localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;

   typedef struct packed {
      logic        flag;
      logic [31:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [SAT_W-1:0] v);
      sat_type r;
      if (v > 70'sd2147483647) begin
         r.flag = 1'b1;
         r.val = 32'h7fffffff;
      end else if (v < -70'sd2147483648) begin
         r.flag = 1'b1;
         r.val = 32'h80000000;
      end else begin
         r.flag = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0: r = 30'h3243F6A8;
         5'd1: r = 30'h1DAC6705;
         5'd2: r = 30'h0FADBAFC;
         5'd3: r = 30'h07F56EA6;
         5'd4: r = 30'h03FEAB76;
         5'd5: r = 30'h01FFD55B;
         5'd6: r = 30'h00FFFAAA;
         5'd7: r = 30'h007FFF55;
         5'd8: r = 30'h003FFFEA;
         5'd9: r = 30'h001FFFFD;
         5'd10: r = 30'h000FFFFF;
         5'd11: r = 30'h0007FFFF;
         5'd12: r = 30'h0003FFFF;
         5'd13: r = 30'h0001FFFF;
         5'd14: r = 30'h0000FFFF;
         5'd15: r = 30'h00007FFF;
         5'd16: r = 30'h00003FFF;
         5'd17: r = 30'h00001FFF;
         5'd18: r = 30'h00000FFF;
         5'd19: r = 30'h000007FF;
         5'd20: r = 30'h000003FF;
         5'd21: r = 30'h000001FF;
         5'd22: r = 30'h000000FF;
         5'd23: r = 30'h0000007F;
         default: r = 30'h0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/aircraft_kinematic_euler_step.sv */
// The sequencer runs N Euler steps per input transfer before raising rsp_valid;
// a step with zero speed skips both divides. Zero steps go straight to the result.
// One item at a time: req_ready is high only in idle, so a new item is taken only after the last result is loaded.
// The per-step cost is set by the bit-serial divider and the CORDIC unit.
// Synchronous active-high reset returns the sequencer to idle and dt to 0.5.
module aircraft_kinematic_euler_step #(
   parameter int MAX_STEPS = akes_pkg::MAX_STEPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [akes_pkg::DT_W-1:0]     csr_step_time,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_pos_x,
   input  logic signed [31:0]            req_pos_y,
   input  logic signed [31:0]            req_pos_z,
   input  logic signed [31:0]            req_heading,
   input  logic signed [31:0]            req_pitch,
   input  logic signed [31:0]            req_speed,
   input  logic signed [31:0]            req_accel,
   input  logic signed [31:0]            req_heading_ctl,
   input  logic signed [31:0]            req_pitch_ctl,
   input  logic [3:0]                    req_step_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_new_x,
   output logic signed [31:0]            rsp_new_y,
   output logic signed [31:0]            rsp_new_z,
   output logic signed [31:0]            rsp_new_heading,
   output logic signed [31:0]            rsp_new_pitch,
   output logic signed [31:0]            rsp_new_speed,
   output logic [1:0]                    rsp_fault
);
   import akes_pkg::*;

   localparam int CW = $clog2(MAX_STEPS + 1);

   typedef enum logic [25:0] {
      ST_IDLE = 26'h0000001,
      ST_CHK  = 26'h0000002,
      ST_MH   = 26'h0000004,
      ST_QH   = 26'h0000008,
      ST_DH   = 26'h0000010,
      ST_MP   = 26'h0000020,
      ST_QP   = 26'h0000040,
      ST_DP   = 26'h0000080,
      ST_MA   = 26'h0000100,
      ST_UA   = 26'h0000200,
      ST_MD   = 26'h0000400,
      ST_UD   = 26'h0000800,
      ST_RH   = 26'h0001000,
      ST_CH   = 26'h0002000,
      ST_RP   = 26'h0004000,
      ST_CP   = 26'h0008000,
      ST_MX1  = 26'h0010000,
      ST_MX2  = 26'h0020000,
      ST_UX   = 26'h0040000,
      ST_MY1  = 26'h0080000,
      ST_MY2  = 26'h0100000,
      ST_UY   = 26'h0200000,
      ST_MZ   = 26'h0400000,
      ST_UZ   = 26'h0800000,
      ST_NXT  = 26'h1000000,
      ST_FIN  = 26'h2000000
   } state_type;

   state_type          state_ff, state_in;
   logic [DT_W-1:0]    dt_ff, dt_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [31:0] h_ff, h_in, p_ff, p_in, v_ff, v_in;
   logic signed [31:0] a_ff, a_in, u_ff, u_in, w_ff, w_in, d_ff, d_in;
   logic signed [31:0] ch_ff, ch_in, sh_ff, sh_in, cp_ff, cp_in, sp_ff, sp_in;
   logic [1:0]         flt_ff, flt_in;
   logic signed [66:0] prod_ff;
   logic signed [33:0] mul_a;
   logic signed [32:0] mul_b;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] ox_ff, oy_ff, oz_ff, oh_ff, op_ff, ov_ff;
   logic [1:0]         of_ff;
   logic               load_out;

   logic [8:0]               sc_ext, sc_lim;
   logic                     div_start, div_done, div_neg;
   logic signed [NUM_W-1:0]  div_num;
   logic [NUM_W-1:0]         div_mag;
   logic signed [NUM_W:0]    quo;
   logic                     sc_start, sc_done;
   logic signed [31:0]       sc_angle, sc_cos, sc_sin;
   sat_type                  s1, s2;

   akes_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (v_ff),
      .done    (div_done),
      .quo_neg (div_neg),
      .quo_mag (div_mag)
   );

   akes_sincos u_sincos (
      .clock   (clock),
      .reset   (reset),
      .start   (sc_start),
      .angle   (sc_angle),
      .done    (sc_done),
      .cos_out (sc_cos),
      .sin_out (sc_sin)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign sc_ext    = 9'(req_step_count);
   assign sc_lim    = (sc_ext > 9'(MAX_STEPS)) ? 9'(MAX_STEPS) : sc_ext;
   // numerator: control*dt floored back to dt's scale, then raised so the quotient by speed lands in the value scale
   assign div_num   = NUM_W'((prod_ff >>> DT_FRAC) <<< FRAC_BITS);
   assign quo       = div_neg ? -signed'({1'b0, div_mag}) : signed'({1'b0, div_mag});
   assign sc_angle  = (state_ff == ST_RH) ? h_ff : p_ff;
   assign sc_start  = (state_ff == ST_RH) || (state_ff == ST_RP);
   assign div_start = (state_ff == ST_QH) || (state_ff == ST_QP);
   assign load_out  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MH: begin mul_a = 34'(u_ff); mul_b = 33'(dt_ff); end
         ST_MP: begin mul_a = 34'(w_ff); mul_b = 33'(dt_ff); end
         ST_MA: begin mul_a = 34'(a_ff); mul_b = 33'(dt_ff); end
         ST_MD: begin mul_a = 34'(v_ff); mul_b = 33'(dt_ff); end
         ST_MX1: begin mul_a = 34'(d_ff); mul_b = 33'(ch_ff); end
         ST_MY1: begin mul_a = 34'(d_ff); mul_b = 33'(sh_ff); end
         ST_MZ: begin mul_a = 34'(d_ff); mul_b = 33'(sp_ff); end
         ST_MX2, ST_MY2: begin
            mul_a = prod_ff[63:30];
            mul_b = 33'(cp_ff);
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      dt_in = dt_ff;
      cnt_in = cnt_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      h_in = h_ff; p_in = p_ff; v_in = v_ff;
      a_in = a_ff; u_in = u_ff; w_in = w_ff; d_in = d_ff;
      ch_in = ch_ff; sh_in = sh_ff; cp_in = cp_ff; sp_in = sp_ff;
      flt_in = flt_ff;
      rsp_valid_in = rsp_valid_ff;
      s1 = '0;
      s2 = '0;
      if (csr_valid && csr_ready) dt_in = csr_step_time;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_out) rsp_valid_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in = req_pos_x; y_in = req_pos_y; z_in = req_pos_z;
               h_in = req_heading; p_in = req_pitch; v_in = req_speed;
               a_in = req_accel; u_in = req_heading_ctl; w_in = req_pitch_ctl;
               cnt_in = sc_lim[CW-1:0];
               flt_in = '0;
               state_in = (sc_lim == 9'd0) ? ST_FIN : ST_CHK;
            end
         end
         ST_CHK: begin
            if (v_ff == 32'sd0) begin
               flt_in[0] = 1'b1;
               state_in = ST_MA;
            end else begin
               state_in = ST_MH;
            end
         end
         ST_MH: state_in = ST_QH;
         ST_QH: state_in = ST_DH;
         ST_DH: begin
            if (div_done) begin
               s1 = sat32(SAT_W'(quo));
               s2 = sat32(SAT_W'(h_ff) + SAT_W'(signed'(s1.val)));
               h_in = s2.val;
               flt_in[1] = flt_ff[1] | s1.flag | s2.flag;
               state_in = ST_MP;
            end
         end
         ST_MP: state_in = ST_QP;
         ST_QP: state_in = ST_DP;
         ST_DP: begin
            if (div_done) begin
               s1 = sat32(SAT_W'(quo));
               s2 = sat32(SAT_W'(p_ff) + SAT_W'(signed'(s1.val)));
               p_in = s2.val;
               flt_in[1] = flt_ff[1] | s1.flag | s2.flag;
               state_in = ST_MA;
            end
         end
         ST_MA: state_in = ST_UA;
         ST_UA: begin
            s1 = sat32(SAT_W'(v_ff) + SAT_W'(signed'(prod_ff[66:DT_FRAC])));
            v_in = s1.val;
            flt_in[1] = flt_ff[1] | s1.flag;
            state_in = ST_MD;
         end
         ST_MD: state_in = ST_UD;
         ST_UD: begin
            s1 = sat32(SAT_W'(signed'(prod_ff[66:DT_FRAC])));
            d_in = s1.val;
            flt_in[1] = flt_ff[1] | s1.flag;
            state_in = ST_RH;
         end
         ST_RH: state_in = ST_CH;
         ST_CH: begin
            if (sc_done) begin
               ch_in = sc_cos;
               sh_in = sc_sin;
               state_in = ST_RP;
            end
         end
         ST_RP: state_in = ST_CP;
         ST_CP: begin
            if (sc_done) begin
               cp_in = sc_cos;
               sp_in = sc_sin;
               state_in = ST_MX1;
            end
         end
         ST_MX1: state_in = ST_MX2;
         ST_MX2: state_in = ST_UX;
         ST_UX: begin
            s1 = sat32(SAT_W'(x_ff) + SAT_W'(signed'(prod_ff[66:ANG_FRAC])));
            x_in = s1.val;
            flt_in[1] = flt_ff[1] | s1.flag;
            state_in = ST_MY1;
         end
         ST_MY1: state_in = ST_MY2;
         ST_MY2: state_in = ST_UY;
         ST_UY: begin
            s1 = sat32(SAT_W'(y_ff) + SAT_W'(signed'(prod_ff[66:ANG_FRAC])));
            y_in = s1.val;
            flt_in[1] = flt_ff[1] | s1.flag;
            state_in = ST_MZ;
         end
         ST_MZ: state_in = ST_UZ;
         ST_UZ: begin
            s1 = sat32(SAT_W'(z_ff) + SAT_W'(signed'(prod_ff[66:ANG_FRAC])));
            z_in = s1.val;
            flt_in[1] = flt_ff[1] | s1.flag;
            state_in = ST_NXT;
         end
         ST_NXT: begin
            cnt_in = cnt_ff - CW'(1);
            state_in = (cnt_ff == CW'(1)) ? ST_FIN : ST_CHK;
         end
         ST_FIN: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dt_ff        <= DT_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         dt_ff        <= dt_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      prod_ff <= mul_a * mul_b;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      h_ff <= h_in; p_ff <= p_in; v_ff <= v_in;
      a_ff <= a_in; u_ff <= u_in; w_ff <= w_in; d_ff <= d_in;
      ch_ff <= ch_in; sh_ff <= sh_in; cp_ff <= cp_in; sp_ff <= sp_in;
      flt_ff <= flt_in;
      if (load_out) begin
         ox_ff <= x_ff; oy_ff <= y_ff; oz_ff <= z_ff;
         oh_ff <= h_ff; op_ff <= p_ff; ov_ff <= v_ff;
         of_ff <= flt_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_x       = ox_ff;
   assign rsp_new_y       = oy_ff;
   assign rsp_new_z       = oz_ff;
   assign rsp_new_heading = oh_ff;
   assign rsp_new_pitch   = op_ff;
   assign rsp_new_speed   = ov_ff;
   assign rsp_fault       = of_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer stayed idle after an input transfer");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DH || state_ff == ST_DP))
      else $error("divider finished outside a divide wait");

   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      sc_done |-> (state_ff == ST_CH || state_ff == ST_CP))
      else $error("sine/cosine unit finished outside its wait");

   a_fin_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (cnt_ff == '0))
      else $error("result issued with steps left");

endmodule

/* rtl/core/akes_div.sv */
module akes_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [akes_pkg::NUM_W-1:0]    num,
   input  logic signed [31:0]                   den,
   output logic                                 done,
   output logic                                 quo_neg,
   output logic [akes_pkg::NUM_W-1:0]           quo_mag
);
   import akes_pkg::*;

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [32:0]         trial;
   logic                take;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 6'(NUM_W - 1);
         quo_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         den_in = den[31] ? 32'(-den) : 32'(den);
         neg_in = num[NUM_W-1] ^ den[31];
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = take ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         quo_in = {quo_ff[NUM_W-2:0], take};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done    = done_ff;
   assign quo_neg = neg_ff;
   assign quo_mag = quo_ff;

endmodule

/* rtl/core/akes_sincos.sv */
module akes_sincos (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] angle,
   output logic               done,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);
   import akes_pkg::*;

   typedef enum logic [3:0] {
      SC_IDLE = 4'b0001,
      SC_RED  = 4'b0010,
      SC_FOLD = 4'b0100,
      SC_ROT  = 4'b1000
   } sc_state_type;

   sc_state_type       state_ff, state_in;
   logic               done_ff, done_in;
   logic [47:0]        mag_ff, mag_in;
   logic               sgn_ff, sgn_in;
   logic               cneg_ff, cneg_in;
   logic [3:0]         red_ff, red_in;
   logic [4:0]         it_ff, it_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [35:0] r_ff, r_in;
   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [47:0] ang_ext;
   logic [47:0]        sub;
   logic signed [35:0] rf, atn;
   logic signed [33:0] xs, ys;

   assign ang_ext = 48'(angle) <<< ANG_UP;
   assign sub     = 48'(TWO_PI_Q30) << red_ff;
   assign atn     = 36'(atan_q30(it_ff));
   assign xs      = x_ff >>> it_ff;
   assign ys      = y_ff >>> it_ff;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      mag_in   = mag_ff;
      sgn_in   = sgn_ff;
      cneg_in  = cneg_ff;
      red_in   = red_ff;
      it_in    = it_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      r_in     = r_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      rf       = '0;
      case (state_ff)
         SC_IDLE: begin
            if (start) begin
               sgn_in   = angle[31];
               mag_in   = angle[31] ? 48'(-ang_ext) : 48'(ang_ext);
               red_in   = 4'd14;
               state_in = SC_RED;
            end
         end
         SC_RED: begin
            if (mag_ff >= sub) mag_in = mag_ff - sub;
            red_in = red_ff - 4'd1;
            if (red_ff == 4'd0) state_in = SC_FOLD;
         end
         SC_FOLD: begin
            rf = signed'(mag_ff[35:0]);
            if (sgn_ff && mag_ff != '0) rf = TWO_PI_Q30 - rf;
            if (rf > PI_Q30) rf = rf - TWO_PI_Q30;
            cneg_in = 1'b0;
            if (rf > HALF_PI_Q30) begin
               rf = PI_Q30 - rf;
               cneg_in = 1'b1;
            end else if (rf < -HALF_PI_Q30) begin
               rf = -PI_Q30 - rf;
               cneg_in = 1'b1;
            end
            r_in     = rf;
            x_in     = GAIN_INV_Q30;
            y_in     = '0;
            it_in    = '0;
            state_in = SC_ROT;
         end
         SC_ROT: begin
            if (r_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               r_in = r_ff - atn;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               r_in = r_ff + atn;
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'(CORDIC_ITERS - 1)) begin
               cos_in   = cneg_ff ? 32'(-x_in) : 32'(x_in);
               sin_in   = 32'(y_in);
               done_in  = 1'b1;
               state_in = SC_IDLE;
            end
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mag_ff  <= mag_in;
      sgn_ff  <= sgn_in;
      cneg_ff <= cneg_in;
      red_ff  <= red_in;
      it_ff   <= it_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      r_ff    <= r_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
